FILE: rtl/core/point_splat_rasterizer_macros.svh
// Assertion helpers for the point splat rasterizer.
`ifndef POINT_SPLAT_RASTERIZER_MACROS_SVH
`define POINT_SPLAT_RASTERIZER_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define PSR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define PSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/psr_pkg.sv
// ----------------------------------------------------------------------------
// psr_pkg
// Shared types and constants of the point splat rasterizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package psr_pkg;

    localparam int COORD_W = 10;
    localparam int DEPTH_W = 31;
    localparam int COLOR_W = 8;
    localparam int SIZE_W  = 4;

    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    localparam logic [2:0] REG_FOCAL_LENGTH = 3'd0;
    localparam logic [2:0] REG_FOCAL_ASPECT = 3'd1;
    localparam logic [2:0] REG_OFFSET_X     = 3'd2;
    localparam logic [2:0] REG_OFFSET_Y     = 3'd3;
    localparam logic [2:0] REG_MIN_COLUMN   = 3'd4;
    localparam logic [2:0] REG_MAX_COLUMN   = 3'd5;
    localparam logic [2:0] REG_MIN_ROW      = 3'd6;
    localparam logic [2:0] REG_MAX_ROW      = 3'd7;

    localparam logic signed [32:0] ONE_Q16 = 33'sd65536;

    // Word passed from the front end to the back end through the queue.
    typedef struct packed {
        logic                 opcode;
        logic signed [31:0]   vertex_x;
        logic signed [31:0]   vertex_y;
        logic signed [31:0]   vertex_z;
        logic [COLOR_W-1:0]   color;
        logic [SIZE_W-1:0]    size;
        logic [COORD_W-1:0]   column_index;
        logic [DEPTH_W-1:0]   column_depth;
        logic [COORD_W-1:0]   column_top;
        logic [COORD_W-1:0]   column_bottom;
    } psr_cmd_t;

    // Configuration seen by the back end.
    typedef struct packed {
        logic [30:0]          focal_length;
        logic [30:0]          focal_aspect;
        logic signed [31:0]   offset_x;
        logic signed [31:0]   offset_y;
        logic [COORD_W-1:0]   min_column;
        logic [COORD_W-1:0]   max_column;
        logic [COORD_W-1:0]   min_row;
        logic [COORD_W-1:0]   max_row;
    } psr_cfg_t;

endpackage
`default_nettype wire

FILE: rtl/core/psr_front.sv
// ----------------------------------------------------------------------------
// psr_front
// Accept input words, drop trivially empty draws, clamp oversize splats, push the rest into a queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "point_splat_rasterizer_macros.svh"
module psr_front
    import psr_pkg::*;
#(
    parameter int MAX_SPLAT = 8,
    parameter int DEPTH     = 4
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire psr_cmd_t in_cmd,
    output logic          q_valid,
    input  wire logic     q_pop,
    output psr_cmd_t      q_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    psr_cmd_t            mem [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]      count_reg, count_next;
    logic                accept;
    logic                keep;
    logic                push;
    psr_cmd_t            cmd_fix;

    assign in_stall = (count_reg == PTR_W'(0) + (PTR_W+1)'(DEPTH));
    assign accept   = in_valid && !in_stall;

    // drop draws that can never emit, clamp oversize splats
    always_comb
    begin
        cmd_fix = in_cmd;
        if (in_cmd.size > SIZE_W'(MAX_SPLAT))
        begin
            cmd_fix.size = SIZE_W'(MAX_SPLAT);
        end
        keep = (in_cmd.opcode == OP_LOAD) ||
               ((in_cmd.color != '0) && (in_cmd.size != '0) &&
                ($signed({in_cmd.vertex_z[31], in_cmd.vertex_z}) > ONE_Q16));
    end

    assign push    = accept && keep;
    assign q_valid = (count_reg != '0);
    assign q_cmd   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= cmd_fix;
        end
    end

    `PSR_ASSERT_IMPL(a_no_pop_empty, clk, rst_n, q_pop, q_valid, "pop from empty queue")
    `PSR_ASSERT_IMPL(a_no_push_full, clk, rst_n, push, !in_stall, "push into full queue")
    `PSR_ASSERT_IMPL(a_count_range, clk, rst_n, 1'b1, count_reg <= (PTR_W+1)'(DEPTH),
        "queue count out of range")

endmodule
`default_nettype wire

FILE: rtl/core/psr_divider.sv
// ----------------------------------------------------------------------------
// psr_divider
// Restoring divider, one quotient bit per cycle, signed numerator.
// Gives floor quotient and nonnegative remainder for a positive divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module psr_divider
    import psr_pkg::*;
#(
    parameter int NUM_W = 66,
    parameter int DEN_W = 49
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0]        den,
    output logic                         done,
    output logic signed [NUM_W-1:0]      quo,
    output logic [DEN_W-1:0]             rem
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  mag_reg, mag_next;
    logic [DEN_W:0]    part_reg, part_next;
    logic [DEN_W-1:0]  den_reg;
    logic              neg_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg;
    logic [DEN_W+1:0]  trial;
    logic [NUM_W-1:0]  num_abs;
    logic [NUM_W-1:0]  qneg;

    assign num_abs = num[NUM_W-1] ? (~num + 1'b1) : num;

    always_comb
    begin
        trial     = {part_reg, mag_reg[NUM_W-1]} - {2'b00, den_reg};
        mag_next  = {mag_reg[NUM_W-2:0], 1'b0};
        part_next = {part_reg[DEN_W-1:0], mag_reg[NUM_W-1]};
        if (!trial[DEN_W+1])
        begin
            mag_next[0] = 1'b1;
            part_next   = trial[DEN_W:0];
        end
        cnt_next = cnt_reg - 1'b1;
    end

    // fold truncated magnitude result into floor division
    always_comb
    begin
        qneg = ~mag_reg + 1'b1;
        if (!neg_reg)
        begin
            quo = mag_reg;
            rem = part_reg[DEN_W-1:0];
        end
        else if (part_reg == '0)
        begin
            quo = qneg;
            rem = '0;
        end
        else
        begin
            quo = qneg - 1'b1;
            rem = den_reg - part_reg[DEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_next;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_reg  <= num_abs;
            part_reg <= '0;
            den_reg  <= den;
            neg_reg  <= num[NUM_W-1];
        end
        else if (busy_reg)
        begin
            mag_reg  <= mag_next;
            part_reg <= part_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/psr_back.sv
// ----------------------------------------------------------------------------
// psr_back
// Load column entries, project vertices, test occlusion, emit splat pixels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "point_splat_rasterizer_macros.svh"
module psr_back
    import psr_pkg::*;
#(
    parameter int COLUMNS   = 1024,
    parameter int MAX_SPLAT = 8
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire psr_cfg_t cfg,
    input  wire logic     q_valid,
    input  wire psr_cmd_t q_cmd,
    output logic          q_pop,
    output logic          out_valid,
    input  wire logic     out_stall,
    output logic [COORD_W-1:0] out_x,
    output logic [COORD_W-1:0] out_y,
    output logic [COLOR_W-1:0] out_color,
    output logic          run_last
);

    localparam int IDX_W = $clog2(COLUMNS);
    localparam int NUM_W = 66;
    localparam int DEN_W = 49;

    typedef enum logic [3:0] {
        S_IDLE, S_MULX, S_DIVX, S_MULY, S_DIVY, S_READ, S_TEST, S_EMIT
    } state_t;

    state_t state_reg;

    logic [DEPTH_W-1:0] depth_mem  [COLUMNS];
    logic [COORD_W-1:0] top_mem    [COLUMNS];
    logic [COORD_W-1:0] bottom_mem [COLUMNS];

    psr_cmd_t                  cmd_reg;
    logic signed [63:0]        prod_a_reg;
    logic signed [63:0]        prod_o_reg;
    logic                      div_start_reg;
    logic                      div_done;
    logic signed [NUM_W-1:0]   div_num;
    logic [DEN_W-1:0]          div_den;
    logic signed [NUM_W-1:0]   div_quo;
    logic [DEN_W-1:0]          div_rem;
    logic signed [NUM_W-1:0]   px_reg, py_reg;
    logic [DEPTH_W-1:0]        rd_depth_reg;
    logic [COORD_W-1:0]        rd_top_reg, rd_bot_reg;
    logic [2:0]                col_reg, row_reg;
    logic signed [NUM_W-1:0]   rounded;
    logic [IDX_W-1:0]          rd_addr;
    logic                      visible;
    logic signed [NUM_W-1:0]   xs, ys;
    logic [COORD_W-1:0]        xc, yc;
    logic [3:0]                half;
    logic                      last_pix;
    logic                      out_take;
    logic signed [31:0]        sel_a;
    logic [30:0]               sel_f;
    logic signed [31:0]        sel_o;

    assign div_num = NUM_W'(prod_a_reg) + NUM_W'(prod_o_reg);
    assign div_den = {1'b0, cmd_reg.vertex_z[31:0], 16'b0};

    psr_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    // round half up: bump when 2*rem >= den
    assign rounded = ({div_rem, 1'b0} >= {1'b0, div_den}) ? div_quo + 1'b1 : div_quo;

    assign rd_addr = IDX_W'(px_reg);
    assign half    = cmd_reg.size >> 1;
    assign last_pix = (col_reg == 3'(cmd_reg.size - 1'b1)) &&
                      (row_reg == 3'(cmd_reg.size - 1'b1));
    assign out_take = out_valid && !out_stall;

    always_comb
    begin
        if (state_reg == S_MULX)
        begin
            sel_a = cmd_reg.vertex_x;
            sel_f = cfg.focal_length;
            sel_o = cfg.offset_x;
        end
        else
        begin
            sel_a = cmd_reg.vertex_y;
            sel_f = cfg.focal_aspect;
            sel_o = cfg.offset_y;
        end
    end

    always_comb
    begin
        visible = (px_reg >= $signed({1'b0, cfg.min_column})) &&
                  (px_reg <= $signed({1'b0, cfg.max_column})) &&
                  (py_reg >= $signed({1'b0, cfg.min_row})) &&
                  (py_reg <= $signed({1'b0, cfg.max_row})) &&
                  ($signed({1'b0, cmd_reg.vertex_z[30:0]}) < $signed({1'b0, rd_depth_reg})) &&
                  (py_reg >= $signed({1'b0, rd_top_reg})) &&
                  (py_reg <= $signed({1'b0, rd_bot_reg}));
        xs = px_reg - NUM_W'(half) + NUM_W'(col_reg);
        ys = py_reg - NUM_W'(half) + NUM_W'(row_reg);
        if (xs < $signed({1'b0, cfg.min_column}))      xc = cfg.min_column;
        else if (xs > $signed({1'b0, cfg.max_column})) xc = cfg.max_column;
        else                                           xc = COORD_W'(xs);
        if (ys < $signed({1'b0, cfg.min_row}))         yc = cfg.min_row;
        else if (ys > $signed({1'b0, cfg.max_row}))    yc = cfg.max_row;
        else                                           yc = COORD_W'(ys);
    end

    assign q_pop = (state_reg == S_IDLE) && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            div_start_reg <= 1'b0;
            out_valid     <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        state_reg <= (q_cmd.opcode == OP_LOAD) ? S_IDLE : S_MULX;
                    end
                end
                S_MULX:
                begin
                    div_start_reg <= 1'b1;
                    state_reg     <= S_DIVX;
                end
                S_DIVX:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_MULY;
                    end
                end
                S_MULY:
                begin
                    div_start_reg <= 1'b1;
                    state_reg     <= S_DIVY;
                end
                S_DIVY:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    if (px_reg < $signed({1'b0, cfg.min_column}) ||
                        px_reg > $signed({1'b0, cfg.max_column}) ||
                        px_reg >= NUM_W'(COLUMNS))
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_TEST;
                    end
                end
                S_TEST:
                begin
                    if (visible)
                    begin
                        state_reg <= S_EMIT;
                        out_valid <= 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_EMIT:
                begin
                    if (out_take && run_last)
                    begin
                        out_valid <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && q_valid)
        begin
            cmd_reg <= q_cmd;
            if (q_cmd.opcode == OP_LOAD && 32'(q_cmd.column_index) < 32'(COLUMNS))
            begin
                depth_mem[IDX_W'(q_cmd.column_index)]  <= q_cmd.column_depth;
                top_mem[IDX_W'(q_cmd.column_index)]    <= q_cmd.column_top;
                bottom_mem[IDX_W'(q_cmd.column_index)] <= q_cmd.column_bottom;
            end
        end
        if (state_reg == S_MULX || state_reg == S_MULY)
        begin
            prod_a_reg <= 64'(sel_a) * $signed({33'b0, sel_f});
            prod_o_reg <= 64'(sel_o) * 64'(cmd_reg.vertex_z);
        end
        if (state_reg == S_DIVX && div_done)
        begin
            px_reg <= rounded;
        end
        if (state_reg == S_DIVY && div_done)
        begin
            py_reg <= rounded;
        end
        if (state_reg == S_READ)
        begin
            rd_depth_reg <= depth_mem[rd_addr];
            rd_top_reg   <= top_mem[rd_addr];
            rd_bot_reg   <= bottom_mem[rd_addr];
        end
        if (state_reg == S_TEST)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (state_reg == S_EMIT && out_take)
        begin
            if (col_reg == 3'(cmd_reg.size - 1'b1))
            begin
                col_reg <= '0;
                row_reg <= row_reg + 1'b1;
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    assign out_x     = xc;
    assign out_y     = yc;
    assign out_color = cmd_reg.color;
    assign run_last  = last_pix;

    `PSR_ASSERT_IMPL(a_emit_valid, clk, rst_n, out_valid, state_reg == S_EMIT,
        "result shown outside emit")
    `PSR_ASSERT_NEXT(a_last_ends, clk, rst_n, out_take && run_last, !out_valid,
        "splat continues after last pixel")
    `PSR_ASSERT_IMPL(a_pop_idle, clk, rst_n, q_pop, state_reg == S_IDLE,
        "queue popped while busy")

endmodule
`default_nettype wire

FILE: rtl/core/point_splat_rasterizer.sv
// Flow: a draw word leaves the queue, then runs the x multiply and divide, the y
// multiply and divide, the table read and the test, then gives size*size pixels
// at one per cycle while out_stall is low; a load word is taken while idle. The
// bit-serial divider is shared by both projections; one word is handled at a time.
// Reset: rst_n is asynchronous, active low; control and configuration registers
// reset, the queue empties, datapath registers and column tables stay undefined.
// ----------------------------------------------------------------------------
// point_splat_rasterizer
// Perspective point splat with per-column occlusion, front queue and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module point_splat_rasterizer
    import psr_pkg::*;
#(
    parameter int COLUMNS   = 1024,
    parameter int MAX_SPLAT = 8
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               opcode,
    input  wire logic signed [31:0] vertex_x,
    input  wire logic signed [31:0] vertex_y,
    input  wire logic signed [31:0] vertex_z,
    input  wire logic [7:0]         pixel_color,
    input  wire logic [3:0]         splat_size,
    input  wire logic               final_vertex,
    input  wire logic [9:0]         column_index,
    input  wire logic [30:0]        column_depth_in,
    input  wire logic [9:0]         column_top_in,
    input  wire logic [9:0]         column_bottom_in,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [9:0]              out_x,
    output logic [9:0]              out_y,
    output logic [7:0]              out_color,
    output logic                    run_last
);

    psr_cfg_t cfg_reg;
    psr_cmd_t in_cmd;
    psr_cmd_t q_cmd;
    logic     q_valid;
    logic     q_pop;
    logic     unused_marker;

    // final_vertex only tags model boundaries; nothing depends on it
    assign unused_marker = final_vertex;

    // hold the register file; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.focal_length <= 31'd10485760;
            cfg_reg.focal_aspect <= 31'd10485760;
            cfg_reg.offset_x     <= 32'sd10485760;
            cfg_reg.offset_y     <= 32'sd6553600;
            cfg_reg.min_column   <= 10'd0;
            cfg_reg.max_column   <= 10'd1023;
            cfg_reg.min_row      <= 10'd0;
            cfg_reg.max_row      <= 10'd1023;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FOCAL_LENGTH: cfg_reg.focal_length <= cfg_data[30:0];
                REG_FOCAL_ASPECT: cfg_reg.focal_aspect <= cfg_data[30:0];
                REG_OFFSET_X:     cfg_reg.offset_x     <= cfg_data;
                REG_OFFSET_Y:     cfg_reg.offset_y     <= cfg_data;
                REG_MIN_COLUMN:   cfg_reg.min_column   <= cfg_data[9:0];
                REG_MAX_COLUMN:   cfg_reg.max_column   <= cfg_data[9:0];
                REG_MIN_ROW:      cfg_reg.min_row      <= cfg_data[9:0];
                REG_MAX_ROW:      cfg_reg.max_row      <= cfg_data[9:0];
                default:          cfg_reg.max_row      <= cfg_reg.max_row;
            endcase
        end
    end

    // pack the input word for the queue
    always_comb
    begin
        in_cmd.opcode        = opcode;
        in_cmd.vertex_x      = vertex_x;
        in_cmd.vertex_y      = vertex_y;
        in_cmd.vertex_z      = unused_marker ? vertex_z : vertex_z;
        in_cmd.color         = pixel_color;
        in_cmd.size          = splat_size;
        in_cmd.column_index  = column_index;
        in_cmd.column_depth  = column_depth_in;
        in_cmd.column_top    = column_top_in;
        in_cmd.column_bottom = column_bottom_in;
    end

    psr_front #(.MAX_SPLAT(MAX_SPLAT), .DEPTH(4)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_cmd   (in_cmd),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_cmd    (q_cmd)
    );

    psr_back #(.COLUMNS(COLUMNS), .MAX_SPLAT(MAX_SPLAT)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_color (out_color),
        .run_last  (run_last)
    );

endmodule
`default_nettype wire

FILE: tb/sv/point_splat_rasterizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_splat_rasterizer_tb
// Self-checking bench: an in-bench projection and occlusion model predicts
// every splat pixel; results are checked in order against the model, under
// random idling on both sides, several register settings, and a long hold on
// the output side.
// ----------------------------------------------------------------------------
module point_splat_rasterizer_tb;
    import psr_pkg::*;

    // Drain allowance: two divides, the tests and a full 8x8 splat.
    localparam int SETTLE_CYCLES = 300;
    localparam int LONG_HOLD     = 3000;

    typedef struct {
        logic [9:0] x;
        logic [9:0] y;
        logic [7:0] color;
        logic       is_last;
    } pixel_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_write = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    wire                in_stall;
    logic               opcode = OP_DRAW;
    logic signed [31:0] vertex_x = '0;
    logic signed [31:0] vertex_y = '0;
    logic signed [31:0] vertex_z = '0;
    logic [7:0]         pixel_color = '0;
    logic [3:0]         splat_size = '0;
    logic               final_vertex = 1'b0;
    logic [9:0]         column_index = '0;
    logic [30:0]        column_depth_in = '0;
    logic [9:0]         column_top_in = '0;
    logic [9:0]         column_bottom_in = '0;
    wire                out_valid;
    logic               out_stall = 1'b0;
    wire [9:0]          out_x;
    wire [9:0]          out_y;
    wire [7:0]          out_color;
    wire                run_last;

    point_splat_rasterizer dut (.*);

    // Clock: 20 ns period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Bench copy of registers and column tables.
    logic [30:0]        m_focal_len;
    logic [30:0]        m_focal_asp;
    logic signed [31:0] m_off_x;
    logic signed [31:0] m_off_y;
    logic [9:0]         m_min_col, m_max_col, m_min_row, m_max_row;
    logic [30:0]        m_depth [1024];
    logic [9:0]         m_top   [1024];
    logic [9:0]         m_bottom[1024];

    pixel_t expected_pixels[$];
    int     mismatches = 0;
    bit     tx_idle_on = 1'b1;
    bit     rx_idle_on = 1'b1;
    bit     hold_req   = 1'b0;

    // round((a*f + o*z) / (z * 2^16)), halves toward +infinity
    function automatic logic signed [95:0] project(logic signed [31:0] a, logic [30:0] f,
                                                   logic signed [31:0] o, logic signed [31:0] z);
        logic signed [95:0] num, den, q, r;
        num = 96'(a) * $signed({65'b0, f}) + 96'(o) * 96'(z);
        den = 96'(z) * 96'sd65536;
        q = num / den;
        r = num - q * den;
        if (r < 0)
        begin
            q = q - 1;
            r = r + den;
        end
        if (2 * r >= den)
            q = q + 1;
        return q;
    endfunction

    // Pick a view coordinate that projects near the target pixel.
    function automatic logic signed [31:0] aim(int target, logic signed [31:0] o,
                                               logic [30:0] f, logic signed [31:0] z);
        logic signed [95:0] v;
        if (f == 0)
            return $urandom;
        v = ((96'(target) <<< 16) - 96'(o)) * 96'(z) / $signed({65'b0, f});
        if (v > 96'sh7FFFFFFF)
            v = 96'sh7FFFFFFF;
        if (v < -96'sh80000000)
            v = -96'sh80000000;
        return v[31:0];
    endfunction

    // Work out the pixels one accepted word produces.
    task automatic predict_splat(logic op, logic signed [31:0] vx, logic signed [31:0] vy,
                                 logic signed [31:0] vz, logic [7:0] color, logic [3:0] size,
                                 logic [9:0] ci, logic [30:0] cd, logic [9:0] ct,
                                 logic [9:0] cb);
        logic signed [95:0] px, py, xx, yy;
        logic signed [95:0] lo_x, hi_x, lo_y, hi_y;
        int sz, half;
        pixel_t p;
        if (op == OP_LOAD)
        begin
            m_depth[ci]  = cd;
            m_top[ci]    = ct;
            m_bottom[ci] = cb;
            return;
        end
        if (color == 0 || size == 0)
            return;
        sz = (size > 8) ? 8 : size;
        if (vz <= 32'sd65536)
            return;
        px = project(vx, m_focal_len, m_off_x, vz);
        py = project(vy, m_focal_asp, m_off_y, vz);
        if (px < 96'(m_min_col) || px > 96'(m_max_col) || px >= 1024)
            return;
        if (96'(vz) >= 96'(m_depth[px[9:0]]))
            return;
        if (py > 96'(m_max_row) || py < 96'(m_min_row))
            return;
        if (py < 96'(m_top[px[9:0]]) || py > 96'(m_bottom[px[9:0]]))
            return;
        lo_x = 96'($signed({1'b0, m_min_col}));
        hi_x = 96'($signed({1'b0, m_max_col}));
        lo_y = 96'($signed({1'b0, m_min_row}));
        hi_y = 96'($signed({1'b0, m_max_row}));
        half = sz / 2;
        for (int i = 0; i < sz * sz; i++)
        begin
            xx = px - half + (i % sz);
            yy = py - half + (i / sz);
            if (xx < lo_x) xx = lo_x;
            if (xx > hi_x) xx = hi_x;
            if (yy < lo_y) yy = lo_y;
            if (yy > hi_y) yy = hi_y;
            p.x = xx[9:0];
            p.y = yy[9:0];
            p.color = color;
            p.is_last = (i == sz * sz - 1);
            expected_pixels.push_back(p);
        end
    endtask

    // Offer one word; hold it until accepted. Valid stays high for a
    // back-to-back word, so it is only lowered when a gap is inserted.
    task automatic send_word(logic op, logic signed [31:0] vx, logic signed [31:0] vy,
                             logic signed [31:0] vz, logic [7:0] color, logic [3:0] size,
                             logic [9:0] ci, logic [30:0] cd, logic [9:0] ct, logic [9:0] cb);
        if (tx_idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid         <= 1'b1;
        opcode           <= op;
        vertex_x         <= vx;
        vertex_y         <= vy;
        vertex_z         <= vz;
        pixel_color      <= color;
        splat_size       <= size;
        final_vertex     <= 1'($urandom_range(0, 1));
        column_index     <= ci;
        column_depth_in  <= cd;
        column_top_in    <= ct;
        column_bottom_in <= cb;
        do
            @(posedge clk);
        while (in_stall);
        predict_splat(op, vx, vy, vz, color, size, ci, cd, ct, cb);
    endtask

    task automatic send_draw(logic signed [31:0] vx, logic signed [31:0] vy,
                             logic signed [31:0] vz, logic [7:0] color, logic [3:0] size);
        send_word(OP_DRAW, vx, vy, vz, color, size, 10'($urandom), 31'($urandom),
                  10'($urandom), 10'($urandom));
    endtask

    task automatic send_load(logic [9:0] ci, logic [30:0] cd, logic [9:0] ct, logic [9:0] cb);
        send_word(OP_LOAD, $urandom, $urandom, $urandom, 8'($urandom), 4'($urandom),
                  ci, cd, ct, cb);
    endtask

    // Drop valid and wait until the block has nothing left in flight.
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write; only called while idle.
    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_FOCAL_LENGTH: m_focal_len = data[30:0];
            REG_FOCAL_ASPECT: m_focal_asp = data[30:0];
            REG_OFFSET_X:     m_off_x     = data;
            REG_OFFSET_Y:     m_off_y     = data;
            REG_MIN_COLUMN:   m_min_col   = data[9:0];
            REG_MAX_COLUMN:   m_max_col   = data[9:0];
            REG_MIN_ROW:      m_min_row   = data[9:0];
            REG_MAX_ROW:      m_max_row   = data[9:0];
            default: ;
        endcase
    endtask

    // Write all eight registers; junk in the unused high bits must be masked.
    task automatic set_view(logic [30:0] fl, logic [30:0] fa, logic [31:0] ox, logic [31:0] oy,
                            int c0, int c1, int r0, int r1);
        settle();
        write_reg(REG_FOCAL_LENGTH, {1'($urandom), fl});
        write_reg(REG_FOCAL_ASPECT, {1'($urandom), fa});
        write_reg(REG_OFFSET_X, ox);
        write_reg(REG_OFFSET_Y, oy);
        write_reg(REG_MIN_COLUMN, {22'($urandom), 10'(c0)});
        write_reg(REG_MAX_COLUMN, {22'($urandom), 10'(c1)});
        write_reg(REG_MIN_ROW, {22'($urandom), 10'(r0)});
        write_reg(REG_MAX_ROW, {22'($urandom), 10'(r1)});
    endtask

    // Depth beyond 1.0, mostly mid range, sometimes right at the limit.
    function automatic logic signed [31:0] pick_depth();
        case ($urandom_range(0, 7))
            0: return 32'sd65537 + $urandom_range(0, 4);
            1: return $urandom_range(65537, 32'h7FFFFFFF);
            default: return $urandom_range(65537, 1 << 23);
        endcase
    endfunction

    function automatic logic [3:0] pick_size();
        case ($urandom_range(0, 15))
            0: return 4'd8;
            1: return 4'($urandom_range(9, 15));
            2: return 4'd0;
            default: return 4'($urandom_range(1, 4));
        endcase
    endfunction

    // Mostly well-aimed draws, some loads and some raw noise.
    task automatic random_words(int count);
        logic signed [31:0] z;
        int tx, ty, lo, hi;
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(0, 9))
                0:  send_load(10'($urandom), 31'($urandom_range(1 << 20, 32'h7FFFFFFF)),
                              10'($urandom_range(0, 30)), 10'($urandom_range(990, 1023)));
                1:  send_draw($urandom, $urandom, $urandom, 8'($urandom), 4'($urandom));
                default:
                begin
                    z  = pick_depth();
                    lo = (m_min_col <= m_max_col) ? m_min_col : m_max_col;
                    hi = (m_min_col <= m_max_col) ? m_max_col : m_min_col;
                    tx = $urandom_range(lo, hi);
                    lo = (m_min_row <= m_max_row) ? m_min_row : m_max_row;
                    hi = (m_min_row <= m_max_row) ? m_max_row : m_min_row;
                    ty = $urandom_range(lo, hi);
                    send_draw(aim(tx, m_off_x, m_focal_len, z), aim(ty, m_off_y, m_focal_asp, z),
                              z, ($urandom_range(0, 15) == 0) ? 8'd0 : 8'($urandom_range(1, 255)),
                              pick_size());
                end
            endcase
        end
    endtask

    // Load columns 0..255 plus the fixed entries; every view after the
    // directed cases keeps its column window inside 0..255 or empty, so no draw
    // ever reads an unwritten entry.
    task automatic test_table_fill();
        for (int c = 0; c < 256; c++)
        begin
            if ($urandom_range(0, 7) == 0)
                send_load(10'(c), 31'($urandom), 10'($urandom), 10'($urandom));
            else
                send_load(10'(c), 31'($urandom_range(1 << 24, 32'h7FFFFFFF)),
                          10'($urandom_range(0, 20)), 10'($urandom_range(1000, 1023)));
        end
        // Fixed entries for the occlusion cases below.
        send_load(10'd200, 31'd196608, 10'd0, 10'd1023);
        send_load(10'd300, 31'h7FFFFFFF, 10'd100, 10'd200);
        send_load(10'd160, 31'h7FFFFFFF, 10'd0, 10'd1023);
        send_load(10'd158, 31'h7FFFFFFF, 10'd0, 10'd1023);
        send_load(10'd163, 31'h7FFFFFFF, 10'd0, 10'd1023);
        send_load(10'd0, 31'h7FFFFFFF, 10'd0, 10'd1023);
        send_load(10'd1023, 31'h7FFFFFFF, 10'd0, 10'd1023);
        settle();
    endtask

    // Directed edges under the reset view: f = 160.0, center (160, 100).
    task automatic test_directed();
        // Depth exactly 1.0, just past it, negative, and the maximum.
        send_draw(0, 0, 32'sd65536, 8'd5, 4'd1);
        send_draw(0, 0, 32'sd65537, 8'd6, 4'd1);
        send_draw(0, 0, -32'sd65536 * 4, 8'd7, 4'd2);
        send_draw(0, 0, 32'sh7FFFFFFF, 8'd255, 4'd1);
        // Transparent, zero size, oversize, full size.
        send_draw(0, 0, 32'sd131072, 8'd0, 4'd3);
        send_draw(0, 0, 32'sd131072, 8'd9, 4'd0);
        send_draw(0, 0, 32'sd131072, 8'd10, 4'd15);
        send_draw(0, 0, 32'sd131072, 8'd11, 4'd8);
        // Exact halves round up on both sides of zero.
        send_draw(32'sd2048, 32'sd2048, 32'sd131072, 8'd12, 4'd1);
        send_draw(-32'sd2048, -32'sd2048, 32'sd131072, 8'd13, 4'd1);
        // Field extremes: far off either edge.
        send_draw(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sd131072, 8'd14, 4'd2);
        send_draw(-32'sh80000000, -32'sh80000000, 32'sd131072, 8'd15, 4'd2);
        // Column 200 occludes at depth 3.0: equal is hidden, nearer is drawn.
        send_draw(aim(200, m_off_x, m_focal_len, 32'sd196608), 0, 32'sd196608, 8'd16, 4'd1);
        send_draw(aim(200, m_off_x, m_focal_len, 32'sd196607), 0, 32'sd196607, 8'd17, 4'd1);
        // Column 300 shows rows 100..200 only.
        send_draw(aim(300, m_off_x, m_focal_len, 32'sd131072),
                  aim(99, m_off_y, m_focal_asp, 32'sd131072), 32'sd131072, 8'd18, 4'd1);
        send_draw(aim(300, m_off_x, m_focal_len, 32'sd131072),
                  aim(150, m_off_y, m_focal_asp, 32'sd131072), 32'sd131072, 8'd19, 4'd3);
        send_draw(aim(300, m_off_x, m_focal_len, 32'sd131072),
                  aim(201, m_off_y, m_focal_asp, 32'sd131072), 32'sd131072, 8'd20, 4'd1);
        // Splats clipped at the window corners.
        send_draw(aim(0, m_off_x, m_focal_len, 32'sd131072),
                  aim(0, m_off_y, m_focal_asp, 32'sd131072), 32'sd131072, 8'd21, 4'd8);
        send_draw(aim(1023, m_off_x, m_focal_len, 32'sd131072),
                  aim(1023, m_off_y, m_focal_asp, 32'sd131072), 32'sd131072, 8'd22, 4'd7);
        settle();
    endtask

    // Walk several views, the register extremes among them.
    task automatic test_view_sweep();
        set_view(31'd33554432, 31'd33554432, 32'd33554432, 32'd33554432, 0, 255, 0, 1023);
        random_words(35);
        set_view(31'h7FFFFFFF, 31'd65536, 32'h80000000, 32'h7FFFFFFF, 0, 255, 0, 1023);
        random_words(20);
        set_view(31'd0, 31'd0, 32'd9863168, 32'd6553600, 0, 255, 0, 1023);
        random_words(15);
        set_view(31'd10485760, 31'd5242880, 32'd33554432, 32'd33554432, 200, 220, 1023, 1023);
        random_words(20);
        set_view(31'd10485760, 31'd10485760, 32'd10485760, 32'd6553600, 1023, 0, 0, 0);
        random_words(10);
        set_view(31'd20971520, 31'd15728640, 32'd3276800, 32'd1638400, 0, 63, 0, 47);
        random_words(35);
        set_view(31'd33554432, 31'd33554432, 32'd33554432, 32'd33554432, 0, 255, 0, 1023);
    endtask

    // Hold the output off long enough that the front queue backs up.
    task automatic test_backpressure();
        hold_req = 1'b1;
        random_words(25);
        settle();
    endtask

    // Closing stretch with no idling on either side.
    task automatic test_streaming();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        random_words(35);
    endtask

    // Output side: random stall bursts plus an optional long hold.
    always @(posedge clk or negedge rst_n)
    begin : stall_gen
        int burst_left;
        int hold_left;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            burst_left = 0;
            hold_left = 0;
        end
        else
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (burst_left > 0)
            begin
                burst_left--;
                out_stall <= 1'b1;
            end
            else if (rx_idle_on && $urandom_range(0, 9) == 0)
            begin
                burst_left = $urandom_range(1, 12) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Compare each accepted pixel with the oldest expectation.
    always @(posedge clk)
    begin : pixel_check
        pixel_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel x=%0d y=%0d color=%0d last=%0b",
                             out_x, out_y, out_color, run_last);
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (out_x !== want.x || out_y !== want.y || out_color !== want.color
                    || run_last !== want.is_last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pixel mismatch: want x=%0d y=%0d c=%0d l=%0b got %0d %0d %0d %0b",
                                 want.x, want.y, want.color, want.is_last,
                                 out_x, out_y, out_color, run_last);
                end
            end
        end
    end

    // Hard stop if the block hangs.
    initial
    begin
        #60ms;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        m_focal_len = 31'd10485760;
        m_focal_asp = 31'd10485760;
        m_off_x     = 32'sd10485760;
        m_off_y     = 32'sd6553600;
        m_min_col   = 10'd0;
        m_max_col   = 10'd1023;
        m_min_row   = 10'd0;
        m_max_row   = 10'd1023;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_table_fill();
        test_directed();
        test_view_sweep();
        test_backpressure();
        test_streaming();
        settle();

        if (expected_pixels.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
